[rtl/ffha_pkg.sv]
// types and constants for the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps
package ffha_pkg;
   localparam int unsigned FIELD_W = 14;
   localparam int unsigned WHOLE_SPARE_LIMIT = 9;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_COMBINE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_HEAP    = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_NO_BLOCK   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] request_size;
      logic [13:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [13:0] data_offset;
      logic [1:0]  status;
      logic [13:0] heap_used;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_WAIT,
      S_EVAL,
      S_SHIFT_RD,
      S_SHIFT_WAIT,
      S_SHIFT_WR,
      S_SPLIT,
      S_SHRINK,
      S_APPEND,
      S_CMB_RD,
      S_CMB_WAIT,
      S_CMB_EVAL,
      S_CMB_DONE,
      S_DONE
   } state_type;
endpackage

[rtl/ffha_table.sv]
// block table memory: one write port, one registered read port
// depends on ffha_pkg
`timescale 1ns / 1ps
module ffha_table #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned IDX_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [14:0]      wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [14:0]      rd_data
);
   import ffha_pkg::*;

   logic [14:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end
endmodule

[rtl/first_fit_heap_allocator.sv]
// first-fit heap allocator: top level, sequencer and shared adder/comparator
// depends on ffha_pkg and ffha_table
// one transaction at a time; a new request is taken the cycle after the response is taken
// block table in a ram with one write port and one registered read port
// synchronous reset clears block count, break and control; table contents undefined
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
   parameter int unsigned HEAP_BYTES = 8192,
   parameter int unsigned META_BYTES = 9,
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned ACC_W = 18;
   localparam logic [ACC_W-1:0] META = ACC_W'(META_BYTES);
   localparam logic [ACC_W-1:0] HEAP = ACC_W'(HEAP_BYTES);
   localparam logic [ACC_W-1:0] LIMIT = ACC_W'(WHOLE_SPARE_LIMIT);
   localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_BLOCKS);

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0] brk_ff, brk_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [ACC_W-1:0] hdr_ff, hdr_in;
   logic [14:0] prev_ff, prev_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic [14:0] wr_data, rd_data;
   logic [ACC_W-1:0] sz, spare, sum_a, sum_b, sum;

   ffha_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
      .rd_idx(rd_idx), .rd_data(rd_data)
   );

   assign sz = ACC_W'(rd_data[13:0]);
   assign spare = sz - ACC_W'(req_ff.request_size);
   assign sum = sum_a + sum_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         brk_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
         brk_ff <= brk_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      i_ff <= i_in;
      k_ff <= k_in;
      hdr_ff <= hdr_in;
      prev_ff <= prev_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (req_ff.command == CMD_NONE || (req_ff.command == CMD_ALLOC
                  && i_ff >= count_ff)) begin
               state_in = (req_ff.command == CMD_NONE) ? S_DONE : S_APPEND;
            end else if (i_ff >= count_ff) begin
               state_in = (req_ff.command == CMD_COMBINE) ? S_CMB_DONE : S_DONE;
            end else if (req_ff.command == CMD_COMBINE) begin
               state_in = S_CMB_WAIT;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_RD;
            if (req_ff.command == CMD_FREE) begin
               if (hdr_ff + META == ACC_W'(req_ff.block_offset)) begin
                  state_in = S_DONE;
               end
            end else if (rd_data[14] && sz >= ACC_W'(req_ff.request_size)) begin
               if (spare <= LIMIT || spare < META || count_ff >= MAXB) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_SHIFT_RD: state_in = (k_ff > i_ff + 1'b1) ? S_SHIFT_WAIT : S_SPLIT;
         S_SHIFT_WAIT: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_SPLIT: state_in = S_SHRINK;
         S_SHRINK: state_in = S_DONE;
         S_APPEND: state_in = S_DONE;
         S_CMB_WAIT: state_in = S_CMB_EVAL;
         S_CMB_EVAL: state_in = S_RD;
         S_CMB_DONE: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in = count_ff;
      brk_in = brk_ff;
      i_in = i_ff;
      k_in = k_ff;
      hdr_in = hdr_ff;
      prev_in = prev_ff;
      wr_en = 1'b0;
      wr_idx = i_ff[IDX_W-1:0];
      wr_data = '0;
      rd_idx = i_ff[IDX_W-1:0];
      sum_a = hdr_ff;
      sum_b = META + sz;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = rsp_valid_ff;
            if (!rsp_valid_ff) begin
               req_in = req_data;
               i_in = '0;
               k_in = '0;
               hdr_in = '0;
               rsp_in.data_offset = '0;
               rsp_in.status = ST_OK;
            end
         end
         S_RD: begin
            if (req_ff.command == CMD_FREE && i_ff >= count_ff) begin
               rsp_in.status = ST_NO_BLOCK;
            end
         end
         S_EVAL: begin
            i_in = i_ff + 1'b1;
            hdr_in = sum;
            if (req_ff.command == CMD_FREE) begin
               if (hdr_ff + META == ACC_W'(req_ff.block_offset)) begin
                  wr_en = 1'b1;
                  wr_data = {1'b1, rd_data[13:0]};
               end
            end else if (rd_data[14] && sz >= ACC_W'(req_ff.request_size)) begin
               sum_b = META;
               rsp_in.data_offset = sum[13:0];
               if (spare <= LIMIT || spare < META) begin
                  wr_en = 1'b1;
                  wr_data = {1'b0, rd_data[13:0]};
               end else if (count_ff >= MAXB) begin
                  rsp_in.data_offset = '0;
                  rsp_in.status = ST_TABLE_FULL;
               end else begin
                  i_in = i_ff;
                  k_in = count_ff;
                  prev_in = {1'b1, 14'(spare - META)};
               end
            end
         end
         S_SHIFT_RD: begin
            rd_idx = IDX_W'(k_ff - 1'b1);
         end
         S_SHIFT_WAIT: begin
            rd_idx = IDX_W'(k_ff - 1'b1);
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_idx = k_ff[IDX_W-1:0];
            wr_data = rd_data;
            k_in = k_ff - 1'b1;
         end
         S_SPLIT: begin
            wr_en = 1'b1;
            wr_idx = IDX_W'(i_ff + 1'b1);
            wr_data = prev_ff;
            count_in = count_ff + 1'b1;
         end
         S_SHRINK: begin
            wr_en = 1'b1;
            wr_data = {1'b0, req_ff.request_size};
         end
         S_APPEND: begin
            sum_a = brk_ff;
            sum_b = ACC_W'(req_ff.request_size) + META;
            if (sum > HEAP) begin
               rsp_in.status = ST_NO_HEAP;
            end else if (count_ff >= MAXB) begin
               rsp_in.status = ST_TABLE_FULL;
            end else begin
               wr_en = 1'b1;
               wr_idx = count_ff[IDX_W-1:0];
               wr_data = {1'b0, req_ff.request_size};
               count_in = count_ff + 1'b1;
               brk_in = sum;
               rsp_in.data_offset = 14'(brk_ff + META);
            end
         end
         S_CMB_EVAL: begin
            i_in = i_ff + 1'b1;
            sum_a = ACC_W'(prev_ff[13:0]);
            if (k_ff != '0 && rd_data[14] && prev_ff[14]) begin
               prev_in = {1'b1, sum[13:0]};
               wr_en = 1'b1;
               wr_idx = IDX_W'(k_ff - 1'b1);
               wr_data = {1'b1, sum[13:0]};
            end else begin
               prev_in = rd_data;
               wr_en = 1'b1;
               wr_idx = k_ff[IDX_W-1:0];
               wr_data = rd_data;
               k_in = k_ff + 1'b1;
            end
         end
         S_CMB_DONE: begin
            count_in = k_ff;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.heap_used = brk_ff[13:0];
            end
         end
         default: begin
         end
      endcase
      if (state_ff == S_SPLIT) begin
         wr_en = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

[rtl/ffha_checker.sv]
// port-level checks for the first-fit heap allocator
// depends on ffha_pkg; bound to first_fit_heap_allocator
`timescale 1ns / 1ps
module ffha_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.data_offset == '0)
      else $error("failed transaction gave an offset");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response after reset");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
